>>> rtl/lfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfg_pkg;

    // bank geometry
    localparam int STREAMS     = 32;
    localparam int LANES       = 4;
    localparam int STREAM_W    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int STREAM_IN_W = 5;
    localparam int OUT_LANES   = 4;

    // history word layout: one row per (stream, position), all lanes side by side
    localparam int PTR_W  = 6;
    localparam int ADDR_W = STREAM_W + PTR_W;
    localparam int FRAC_W = 16;
    localparam int WORD_W = LANES * FRAC_W;
    localparam int SEED_W = 32;

    localparam logic [PTR_W-1:0] HIST_LAST   = 6'd54;
    localparam logic [PTR_W-1:0] SHORT_START = 6'd23;
    localparam logic [PTR_W-1:0] LONG_START  = 6'd54;

    localparam logic [SEED_W-1:0] SEED_MULT = 32'd3141592621;

    typedef enum logic
    {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ADD,
        ST_SEED
    } state_t;

    typedef struct packed
    {
        logic                   op;
        logic [STREAM_IN_W-1:0] stream;
    } in_item_t;

    typedef struct packed
    {
        logic [FRAC_W-1:0] rand_lane0;
        logic [FRAC_W-1:0] rand_lane1;
        logic [FRAC_W-1:0] rand_lane2;
        logic [FRAC_W-1:0] rand_lane3;
    } out_item_t;

    typedef struct packed
    {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

    typedef struct packed
    {
        logic issue;
        logic commit;
        logic clear_ptrs;
    } draw_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lfg_hist_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lfg_hist_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lfg_seeder.sv
`timescale 1ns / 1ps
`default_nettype none

module lfg_seeder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [lfg_pkg::SEED_W-1:0]   seed_value,
    output lfg_pkg::mem_wr_t                  wr,
    output logic                              done
);

    logic                          active_reg;
    logic [lfg_pkg::STREAM_W-1:0]  strm_cnt_reg;
    logic [lfg_pkg::PTR_W-1:0]     word_cnt_reg;
    logic [lfg_pkg::LANE_W-1:0]    lane_cnt_reg;
    logic [lfg_pkg::SEED_W-1:0]    x_reg;
    logic [lfg_pkg::SEED_W-1:0]    x_next;
    logic [lfg_pkg::LANES-1:0][lfg_pkg::FRAC_W-1:0] lane_buf_reg;
    logic [lfg_pkg::LANES-1:0][lfg_pkg::FRAC_W-1:0] word_data;

    logic [lfg_pkg::SEED_W-1:0] x_inc;
    logic [lfg_pkg::SEED_W-1:0] x_mul;
    logic [lfg_pkg::SEED_W-1:0] x_restart;
    logic [lfg_pkg::FRAC_W-1:0] value;
    logic                       last_lane;
    logic                       last_word;
    logic                       last_strm;

    assign value     = x_reg[lfg_pkg::SEED_W-1 -: lfg_pkg::FRAC_W];
    assign last_lane = (lane_cnt_reg == lfg_pkg::LANE_W'(lfg_pkg::LANES - 1));
    assign last_word = (word_cnt_reg == lfg_pkg::HIST_LAST);
    assign last_strm = (strm_cnt_reg == lfg_pkg::STREAM_W'(lfg_pkg::STREAMS - 1));

    // sequence step and per-stream restart value
    assign x_inc     = x_reg + 32'd1;
    assign x_mul     = x_inc * lfg_pkg::SEED_MULT;
    assign x_restart = seed_value + lfg_pkg::SEED_W'(strm_cnt_reg) + 32'd1;

    always_comb
    begin
        x_next = x_reg;
        if (start)
        begin
            x_next = seed_value;
        end
        else if (active_reg)
        begin
            if (last_lane && last_word)
            begin
                x_next = x_restart;
            end
            else
            begin
                x_next = x_mul;
            end
        end
    end

    // assemble the row: current value lands in its lane, earlier lanes from the buffer
    for (genvar l = 0; l < lfg_pkg::LANES; l++)
    begin : g_word
        assign word_data[l] = (lane_cnt_reg == lfg_pkg::LANE_W'(l)) ? value : lane_buf_reg[l];
    end

    assign wr.en   = active_reg && last_lane;
    assign wr.addr = {strm_cnt_reg, word_cnt_reg};
    assign wr.data = word_data;
    assign done    = active_reg && last_lane && last_word && last_strm;

    // sequence register and lane buffer
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (active_reg)
        begin
            lane_buf_reg[lane_cnt_reg] <= value;
        end
    end

    // fill counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            strm_cnt_reg <= '0;
            word_cnt_reg <= '0;
            lane_cnt_reg <= '0;
        end
        else if (start)
        begin
            active_reg   <= 1'b1;
            strm_cnt_reg <= '0;
            word_cnt_reg <= '0;
            lane_cnt_reg <= '0;
        end
        else if (active_reg)
        begin
            if (done)
            begin
                active_reg <= 1'b0;
            end
            if (last_lane)
            begin
                lane_cnt_reg <= '0;
                if (last_word)
                begin
                    word_cnt_reg <= '0;
                    strm_cnt_reg <= last_strm ? '0 : strm_cnt_reg + 1'b1;
                end
                else
                begin
                    word_cnt_reg <= word_cnt_reg + 1'b1;
                end
            end
            else
            begin
                lane_cnt_reg <= lane_cnt_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/lfg_draw.sv
`timescale 1ns / 1ps
`default_nettype none

module lfg_draw (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lfg_pkg::draw_ctl_t              ctl,
    input  wire logic [lfg_pkg::STREAM_IN_W-1:0] stream,
    output logic      [lfg_pkg::ADDR_W-1:0]      rd_addr_long,
    output logic      [lfg_pkg::ADDR_W-1:0]      rd_addr_short,
    input  wire logic [lfg_pkg::WORD_W-1:0]      rd_long,
    input  wire logic [lfg_pkg::WORD_W-1:0]      rd_short,
    output lfg_pkg::mem_wr_t                     wr,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output lfg_pkg::out_item_t                   out_data,
    output logic                                 out_free
);

    logic [lfg_pkg::PTR_W-1:0]    short_ptr_reg [lfg_pkg::STREAMS];
    logic [lfg_pkg::PTR_W-1:0]    long_ptr_reg  [lfg_pkg::STREAMS];
    logic [lfg_pkg::STREAM_W-1:0] cur_strm_reg;
    logic [lfg_pkg::PTR_W-1:0]    short_reg;
    logic [lfg_pkg::PTR_W-1:0]    long_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    lfg_pkg::out_item_t           out_data_reg;
    lfg_pkg::out_item_t           out_data_next;

    logic [lfg_pkg::STREAM_W+lfg_pkg::STREAM_IN_W-1:0] stream_ext;
    logic [lfg_pkg::STREAM_W-1:0]                      idx;
    logic [lfg_pkg::LANES-1:0][lfg_pkg::FRAC_W-1:0]    lane_sum;
    logic [lfg_pkg::OUT_LANES-1:0][lfg_pkg::FRAC_W-1:0] out_lanes;

    function automatic logic [lfg_pkg::PTR_W-1:0] step_back(input logic [lfg_pkg::PTR_W-1:0] p);
        return (p == '0) ? lfg_pkg::HIST_LAST : p - 1'b1;
    endfunction

    // stream select and lag reads
    assign stream_ext    = {{lfg_pkg::STREAM_W{1'b0}}, stream};
    assign idx           = stream_ext[lfg_pkg::STREAM_W-1:0];
    assign rd_addr_long  = {idx, long_ptr_reg[idx]};
    assign rd_addr_short = {idx, short_ptr_reg[idx]};

    // one adder per lane
    for (genvar l = 0; l < lfg_pkg::LANES; l++)
    begin : g_lane
        assign lane_sum[l] = rd_long[l*lfg_pkg::FRAC_W +: lfg_pkg::FRAC_W]
                           + rd_short[l*lfg_pkg::FRAC_W +: lfg_pkg::FRAC_W];
    end

    // write back at the long lag
    assign wr.en   = ctl.commit;
    assign wr.addr = {cur_strm_reg, long_reg};
    assign wr.data = lane_sum;

    // merge lanes into the result fields
    for (genvar g = 0; g < lfg_pkg::OUT_LANES; g++)
    begin : g_merge
        if (g < lfg_pkg::LANES)
        begin : g_used
            assign out_lanes[g] = lane_sum[g];
        end
        else
        begin : g_absent
            assign out_lanes[g] = '0;
        end
    end

    always_comb
    begin
        out_data_next.rand_lane0 = out_lanes[0];
        out_data_next.rand_lane1 = out_lanes[1];
        out_data_next.rand_lane2 = out_lanes[2];
        out_data_next.rand_lane3 = out_lanes[3];
    end

    // output register
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_data_reg <= out_data_next;
        end
        if (ctl.issue)
        begin
            cur_strm_reg <= idx;
            short_reg    <= short_ptr_reg[idx];
            long_reg     <= long_ptr_reg[idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // per-stream lag pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < lfg_pkg::STREAMS; s++)
            begin
                short_ptr_reg[s] <= lfg_pkg::SHORT_START;
                long_ptr_reg[s]  <= lfg_pkg::LONG_START;
            end
        end
        else if (ctl.clear_ptrs)
        begin
            for (int s = 0; s < lfg_pkg::STREAMS; s++)
            begin
                short_ptr_reg[s] <= lfg_pkg::SHORT_START;
                long_ptr_reg[s]  <= lfg_pkg::LONG_START;
            end
        end
        else if (ctl.commit)
        begin
            short_ptr_reg[cur_strm_reg] <= step_back(short_reg);
            long_ptr_reg[cur_strm_reg]  <= step_back(long_reg);
        end
    end

endmodule

`default_nettype wire

>>> rtl/lagged_fibonacci_rng_multistream.sv
// Bank of 32 additive lagged Fibonacci generators (lags 24 and 55), four 16-bit lanes each.
// A draw (op 0) on one stream returns four fractions: the transfer registers the two-port
// history read, and the add step then does the lane adds and the write-back and registers the
// result; the next item is taken in the cycle after, and the draw waits in its add step
// while the output register still holds an untaken result. A reseed (op 1) refills every
// stream from seed_value and gives no result; it runs one sequence multiply per cycle, and no
// item is taken while it runs. The history memory is not cleared at reset, so draws before
// the first reseed return undefined values. seed_value is written through cfg_we/cfg_data and
// resets to zero; the user must write it only while idle, as the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module lagged_fibonacci_rng_multistream (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire lfg_pkg::in_item_t            in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output lfg_pkg::out_item_t                out_data,
    input  wire logic                         cfg_we,
    input  wire logic [lfg_pkg::SEED_W-1:0]   cfg_data
);

    lfg_pkg::state_t    state_reg;
    lfg_pkg::state_t    state_next;
    lfg_pkg::draw_ctl_t ctl;
    lfg_pkg::mem_wr_t   seed_wr;
    lfg_pkg::mem_wr_t   draw_wr;
    lfg_pkg::mem_wr_t   mem_wr;

    logic [lfg_pkg::SEED_W-1:0] seed_value_reg;
    logic                       seed_start;
    logic                       seed_done;
    logic                       draw_ok;
    logic                       out_free;
    logic [lfg_pkg::ADDR_W-1:0] rd_addr_long;
    logic [lfg_pkg::ADDR_W-1:0] rd_addr_short;
    logic [lfg_pkg::WORD_W-1:0] rd_long;
    logic [lfg_pkg::WORD_W-1:0] rd_short;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            seed_value_reg <= cfg_data;
        end
    end

    assign draw_ok = (9'(in_data.stream) < 9'(lfg_pkg::STREAMS));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        seed_start     = 1'b0;
        ctl.issue      = 1'b0;
        ctl.commit     = 1'b0;
        ctl.clear_ptrs = 1'b0;
        unique case (state_reg)
            lfg_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_data.op == lfg_pkg::OP_RESEED)
                    begin
                        seed_start     = 1'b1;
                        ctl.clear_ptrs = 1'b1;
                        state_next     = lfg_pkg::ST_SEED;
                    end
                    else if (draw_ok)
                    begin
                        ctl.issue  = 1'b1;
                        state_next = lfg_pkg::ST_ADD;
                    end
                end
            end
            lfg_pkg::ST_ADD:
            begin
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = lfg_pkg::ST_IDLE;
                end
            end
            lfg_pkg::ST_SEED:
            begin
                if (seed_done)
                begin
                    state_next = lfg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfg_pkg::ST_IDLE;
            end
        endcase
    end

    // write port goes to the fill sequencer while reseeding
    assign mem_wr = (state_reg == lfg_pkg::ST_SEED) ? seed_wr : draw_wr;

    lfg_seeder u_seeder (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (seed_start),
        .seed_value (seed_value_reg),
        .wr         (seed_wr),
        .done       (seed_done)
    );

    lfg_draw u_draw (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stream        (in_data.stream),
        .rd_addr_long  (rd_addr_long),
        .rd_addr_short (rd_addr_short),
        .rd_long       (rd_long),
        .rd_short      (rd_short),
        .wr            (draw_wr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .out_free      (out_free)
    );

    lfg_hist_ram #(
        .ADDR_W (lfg_pkg::ADDR_W),
        .DATA_W (lfg_pkg::WORD_W)
    ) u_hist (
        .clk     (clk),
        .we      (mem_wr.en),
        .waddr   (mem_wr.addr),
        .wdata   (mem_wr.data),
        .re      (ctl.issue),
        .raddr_a (rd_addr_long),
        .raddr_b (rd_addr_short),
        .rdata_a (rd_long),
        .rdata_b (rd_short)
    );

    // a new result only ever comes out of the add step
    a_result_from_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == lfg_pkg::ST_ADD)
        else $error("result appeared outside the add step");

    // fill sequencer finishes only while reseeding
    a_seed_done_in_seed: assert property (@(posedge clk) disable iff (!rst_n)
        seed_done |-> state_reg == lfg_pkg::ST_SEED)
        else $error("fill sequencer active outside reseed");

    // an empty output register lets the add step finish at once
    a_add_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfg_pkg::ST_ADD && !out_valid) |=> state_reg == lfg_pkg::ST_IDLE)
        else $error("draw held with a free output register");

    // no fill write lands during a draw
    a_no_seed_write_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lfg_pkg::ST_ADD |-> !seed_wr.en)
        else $error("fill write during a draw");

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int HIST_LEN      = int'(lfg_pkg::HIST_LAST) + 1;
    localparam int RESEED_CYCLES = lfg_pkg::STREAMS * HIST_LEN * lfg_pkg::LANES;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 290;

    // clock and block ports
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    lfg_pkg::in_item_t          in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    lfg_pkg::out_item_t         out_data;
    logic                       cfg_we    = 1'b0;
    logic [lfg_pkg::SEED_W-1:0] cfg_data  = '0;

    // shared control of the idling behavior
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int failures     = 0;

    // generator bank as predicted
    logic [lfg_pkg::FRAC_W-1:0] lfg_history [lfg_pkg::STREAMS][HIST_LEN][lfg_pkg::LANES];
    logic [lfg_pkg::PTR_W-1:0]  short_lag   [lfg_pkg::STREAMS];
    logic [lfg_pkg::PTR_W-1:0]  long_lag    [lfg_pkg::STREAMS];
    logic [lfg_pkg::SEED_W-1:0] seed_reg;
    lfg_pkg::out_item_t         expected_draws [$];

    lagged_fibonacci_rng_multistream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // pointer moves down one position, wrapping to the top
    function automatic logic [lfg_pkg::PTR_W-1:0] lag_step_back(
        input logic [lfg_pkg::PTR_W-1:0] p);
        if (p == '0 || p > lfg_pkg::HIST_LAST)
            return lfg_pkg::HIST_LAST;
        return p - 1'b1;
    endfunction

    // advance the predicted bank by one accepted item
    function automatic void predict_item(input lfg_pkg::in_item_t item);
        logic [lfg_pkg::SEED_W-1:0]                         x;
        logic [lfg_pkg::PTR_W-1:0]                          jp;
        logic [lfg_pkg::PTR_W-1:0]                          kp;
        logic [lfg_pkg::FRAC_W-1:0]                         sum;
        logic [lfg_pkg::OUT_LANES-1:0][lfg_pkg::FRAC_W-1:0] lanes;
        if (item.op == lfg_pkg::OP_RESEED)
        begin
            for (int s = 0; s < lfg_pkg::STREAMS; s++)
            begin
                x = seed_reg + lfg_pkg::SEED_W'(s);
                short_lag[s] = lfg_pkg::SHORT_START;
                long_lag[s]  = lfg_pkg::LONG_START;
                for (int i = 0; i < HIST_LEN; i++)
                begin
                    for (int j = 0; j < lfg_pkg::LANES; j++)
                    begin
                        lfg_history[s][i][j] =
                            x[lfg_pkg::SEED_W-1:lfg_pkg::SEED_W-lfg_pkg::FRAC_W];
                        x = (x + 1'b1) * lfg_pkg::SEED_MULT;
                    end
                end
            end
            return;
        end
        if (int'(item.stream) >= lfg_pkg::STREAMS)
            return;
        jp = short_lag[item.stream];
        kp = long_lag[item.stream];
        if (jp > lfg_pkg::HIST_LAST)
            jp = lfg_pkg::HIST_LAST;
        if (kp > lfg_pkg::HIST_LAST)
            kp = lfg_pkg::HIST_LAST;
        lanes = '0;
        for (int j = 0; j < lfg_pkg::LANES; j++)
        begin
            sum = lfg_history[item.stream][kp][j] + lfg_history[item.stream][jp][j];
            lfg_history[item.stream][kp][j] = sum;
            // lane 0 sits in the top bits of the result
            if (j < lfg_pkg::OUT_LANES)
                lanes[lfg_pkg::OUT_LANES-1-j] = sum;
        end
        short_lag[item.stream] = lag_step_back(jp);
        long_lag[item.stream]  = lag_step_back(kp);
        expected_draws.push_back(lfg_pkg::out_item_t'(lanes));
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // offer one item and wait for its transfer
    task automatic send_item(input lfg_pkg::in_item_t item);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(item);
    endtask

    task automatic send_draw(input int unsigned stream);
        lfg_pkg::in_item_t item;
        item.op     = lfg_pkg::OP_DRAW;
        item.stream = stream[lfg_pkg::STREAM_IN_W-1:0];
        send_item(item);
    endtask

    task automatic send_reseed();
        lfg_pkg::in_item_t item;
        item.op     = lfg_pkg::OP_RESEED;
        item.stream = lfg_pkg::STREAM_IN_W'($urandom_range(0, 31));
        send_item(item);
    endtask

    // drain results, then let a possible reseed run out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (RESEED_CYCLES + 64) @(posedge clk);
    endtask

    task automatic write_seed(input logic [lfg_pkg::SEED_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seed_reg  = value;
    endtask

    // reset seed of zero, stream extremes, back-to-back draws on one stream
    task automatic test_default_seed();
        send_reseed();
        send_draw(0);
        send_draw(31);
        send_draw(0);
        send_draw(0);
        send_draw(0);
        send_draw(16);
        send_draw(31);
        wait_idle();
    endtask

    // all-ones seed, so seed plus stream index wraps
    task automatic test_max_seed();
        write_seed('1);
        send_reseed();
        send_draw(31);
        send_draw(31);
        send_draw(1);
        send_draw(30);
        wait_idle();
    endtask

    // reseed in the middle of a run puts the pointers back
    task automatic test_reseed_restart();
        write_seed('0);
        send_reseed();
        send_draw(5);
        send_draw(5);
        send_reseed();
        send_draw(5);
        send_draw(10);
        send_draw(21);
        wait_idle();
    endtask

    // receiver holds off long while draws keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++)
            send_draw((n % 3 == 0) ? 7 : $urandom_range(0, 31));
        wait_idle();
    endtask

    // random seeds, draws mostly on a few hot streams so the pointers wrap often
    task automatic test_random_phases();
        int unsigned hot [3];
        for (int p = 0; p < PHASES; p++)
        begin
            write_seed($urandom());
            quiet = (p == 2);
            for (int h = 0; h < 3; h++)
                hot[h] = $urandom_range(0, 31);
            send_reseed();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 249) == 0)
                    send_reseed();
                else if ($urandom_range(0, 9) < 7)
                    send_draw(hot[$urandom_range(0, 2)]);
                else
                    send_draw($urandom_range(0, 31));
            end
            quiet = 1'b0;
            wait_idle();
        end
    endtask

    // receiver: random stall runs, a long hold on request
    initial
    begin : receiver
        int unsigned run;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                run = HOLD_CYCLES;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                run = 1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                run = pick_gap() + 1;
            end
            repeat (run) @(posedge clk);
        end
    end

    // compare each result transfer with the oldest predicted draw
    always @(posedge clk)
    begin : check_draw
        logic [lfg_pkg::OUT_LANES-1:0][lfg_pkg::FRAC_W-1:0] got;
        logic [lfg_pkg::OUT_LANES-1:0][lfg_pkg::FRAC_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = out_data;
            if (expected_draws.size() == 0)
            begin
                $error("draw result %h with none expected", got);
                failures++;
            end
            else
            begin
                want = expected_draws.pop_front();
                for (int j = 0; j < lfg_pkg::OUT_LANES; j++)
                begin
                    if (got[lfg_pkg::OUT_LANES-1-j] !== want[lfg_pkg::OUT_LANES-1-j])
                    begin
                        $error("rand_lane%0d expected %h actual %h", j,
                               want[lfg_pkg::OUT_LANES-1-j], got[lfg_pkg::OUT_LANES-1-j]);
                        failures++;
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        seed_reg = '0;
        for (int s = 0; s < lfg_pkg::STREAMS; s++)
        begin
            short_lag[s] = lfg_pkg::SHORT_START;
            long_lag[s]  = lfg_pkg::LONG_START;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_seed();
        test_max_seed();
        test_reseed_restart();
        test_backpressure();
        test_random_phases();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
